FILE: rtl/core/dfs_topological_sort_macros.svh
// Assertion macros shared by the sort core.
`ifndef DFS_TOPOLOGICAL_SORT_MACROS_SVH
`define DFS_TOPOLOGICAL_SORT_MACROS_SVH
`ifndef SYNTHESIS
`define DTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DTS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DTS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/dts_pkg.sv
package dts_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges = 256;
  localparam int VW = 6;
  localparam int EW = 9;
  localparam logic [EW-1:0] NullLink = EW'(MaxEdges);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SORT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [VW-1:0] vertex;
    logic          last;
  } emit_t;
endpackage

FILE: rtl/core/dts_post_buf.sv
// Postorder buffer: written during the search, read back in reverse.
module dts_post_buf (
  input  logic                   clk,
  input  logic                   we,
  input  logic [dts_pkg::VW-1:0] waddr,
  input  logic [dts_pkg::VW-1:0] wdata,
  input  logic [dts_pkg::VW-1:0] raddr,
  output logic [dts_pkg::VW-1:0] rdata
);
  logic [dts_pkg::VW-1:0] mem [dts_pkg::MaxVertices];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/dts_engine.sv
`include "dfs_topological_sort_macros.svh"
// Graph store and depth-first search sequencer.
module dts_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [6:0]             vcount,
  input  logic                   start,
  input  logic [1:0]             operation,
  input  logic [dts_pkg::VW-1:0] edge_source,
  input  logic [dts_pkg::VW-1:0] edge_target,
  output logic                   busy,
  output logic                   done,
  output dts_pkg::emit_t         emit,
  output logic                   dropped
);
  localparam int VW = dts_pkg::VW;
  localparam int EW = dts_pkg::EW;
  localparam int MV = dts_pkg::MaxVertices;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_ROOT, S_PUSH, S_TOP, S_TOP_WAIT,
    S_EDGE, S_EDGE_CHK, S_EMIT_RD, S_EMIT
  } state_t;

  state_t state;

  // Edge pool memories.
  logic [VW-1:0] tgt_mem  [dts_pkg::MaxEdges];
  logic [EW-1:0] link_mem [dts_pkg::MaxEdges];
  logic [EW-1:0] head_mem [MV];
  logic [EW-1:0] tail_mem [MV];
  logic [MV-1:0] list_valid;
  logic [VW+EW-1:0] stack_mem [MV];

  logic [EW-1:0] edge_total;
  logic [MV-1:0] visited;
  logic [6:0]    n;
  logic [6:0]    sp;
  logic [6:0]    root;
  logic [6:0]    count;
  logic [6:0]    k;
  logic [VW-1:0] src_q, dst_q;
  logic [VW-1:0] top_v;
  logic [EW-1:0] top_link;
  logic [VW-1:0] push_v;

  // Registered read ports.
  logic [EW-1:0]    tail_rd, head_rd, link_rd;
  logic [VW-1:0]    tgt_rd;
  logic [VW+EW-1:0] stack_rd;
  logic [EW-1:0]    tail_val, head_val;
  logic [VW-1:0]    head_addr;

  logic          pb_we;
  logic [VW-1:0] pb_waddr, pb_raddr, pb_rdata;

  assign n = (vcount > 7'(MV)) ? 7'(MV) : vcount;
  assign busy = (state != S_IDLE);

  // While checking an edge the head read goes to its target, so a push can use it next cycle.
  assign head_addr = (state == S_ROOT) ? root[VW-1:0] : tgt_rd;

  always_ff @(posedge clk) begin
    tail_rd <= tail_mem[src_q];
    head_rd <= head_mem[head_addr];
    stack_rd <= stack_mem[sp[VW-1:0] - VW'(1)];
    tgt_rd <= tgt_mem[top_link[EW-2:0]];
    link_rd <= link_mem[top_link[EW-2:0]];
  end

  assign tail_val = list_valid[src_q] ? tail_rd : dts_pkg::NullLink;
  assign head_val = list_valid[push_v] ? head_rd : dts_pkg::NullLink;

  assign pb_we = (state == S_TOP) && (stack_rd[EW-1:0] == dts_pkg::NullLink)
                 && (count < 7'(MV));
  assign pb_waddr = count[VW-1:0];
  assign pb_raddr = 6'(count - 7'd1 - k);

  dts_post_buf u_buf (
    .clk(clk), .we(pb_we), .waddr(pb_waddr), .wdata(stack_rd[EW+VW-1:EW]),
    .raddr(pb_raddr), .rdata(pb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      edge_total <= '0;
      list_valid <= '0;
      dropped <= 1'b0;
      done <= 1'b0;
      visited <= '0;
      sp <= '0;
      root <= '0;
      count <= '0;
      k <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            src_q <= edge_source;
            dst_q <= edge_target;
            unique case (dts_pkg::op_t'(operation))
              dts_pkg::OP_ADD: begin
                if ({1'b0, edge_source} >= n || {1'b0, edge_target} >= n ||
                    edge_total >= dts_pkg::NullLink) begin
                  dropped <= 1'b1;
                end else begin
                  state <= S_ADD_RD;
                end
              end
              dts_pkg::OP_SORT: begin
                visited <= '0;
                sp <= '0;
                root <= '0;
                count <= '0;
                state <= S_ROOT;
              end
              dts_pkg::OP_CLEAR: begin
                list_valid <= '0;
                edge_total <= '0;
                dropped <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_ADD_RD: begin
          // The new edge is written while the tail read is in flight.
          tgt_mem[edge_total[EW-2:0]] <= dst_q;
          link_mem[edge_total[EW-2:0]] <= dts_pkg::NullLink;
          state <= S_ADD_WR;
        end
        S_ADD_WR: begin
          if (tail_val != dts_pkg::NullLink) begin
            link_mem[tail_val[EW-2:0]] <= edge_total;
          end else begin
            head_mem[src_q] <= edge_total;
          end
          tail_mem[src_q] <= edge_total;
          list_valid[src_q] <= 1'b1;
          edge_total <= edge_total + EW'(1);
          state <= S_IDLE;
        end
        S_ROOT: begin
          // Head read issued for root this cycle.
          if (root >= n) begin
            k <= '0;
            state <= (count == '0) ? S_IDLE : S_EMIT_RD;
          end else if (visited[root[VW-1:0]]) begin
            root <= root + 7'd1;
          end else begin
            push_v <= root[VW-1:0];
            root <= root + 7'd1;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          visited[push_v] <= 1'b1;
          stack_mem[sp[VW-1:0]] <= {push_v, head_val};
          sp <= sp + 7'd1;
          state <= S_TOP_WAIT;
        end
        S_TOP_WAIT: state <= S_TOP;
        S_TOP: begin
          if (stack_rd[EW-1:0] == dts_pkg::NullLink) begin
            if (count < 7'(MV)) count <= count + 7'd1;
            sp <= sp - 7'd1;
            state <= (sp == 7'd1) ? S_ROOT : S_TOP_WAIT;
          end else begin
            top_v <= stack_rd[EW+VW-1:EW];
            top_link <= stack_rd[EW-1:0];
            state <= S_EDGE;
          end
        end
        S_EDGE: state <= S_EDGE_CHK;
        S_EDGE_CHK: begin
          stack_mem[sp[VW-1:0] - VW'(1)] <= {top_v, link_rd};
          if ({1'b0, tgt_rd} < n && !visited[tgt_rd]) begin
            push_v <= tgt_rd;
            state <= S_PUSH;
          end else begin
            state <= S_TOP_WAIT;
          end
        end
        S_EMIT_RD: state <= S_EMIT;
        S_EMIT: begin
          done <= 1'b1;
          emit.vertex <= pb_rdata;
          emit.last <= (k + 7'd1 == count);
          k <= k + 7'd1;
          state <= (k + 7'd1 == count) ? S_IDLE : S_EMIT_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTS_ASSERT_IMPL(a_sp_bound, clk, rst, 1'b1, sp <= 7'(MV))
  `DTS_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, count <= 7'(MV))
  `DTS_ASSERT_NEXT(a_push_mark, clk, rst, state == S_PUSH, visited[$past(push_v)])
  `DTS_ASSERT_IMPL(a_edges, clk, rst, 1'b1, edge_total <= dts_pkg::NullLink)
endmodule

FILE: rtl/core/dfs_topological_sort.sv
// Depth-first topological sort. Edges load with operation 0 through the
// add read and write states; a dropped edge is flagged from idle, and clear (2)
// acts from idle. A sort (1) walks the graph through a stack memory with
// registered reads, then emits the reversed postorder one beat at a time on
// done, alternating emit read and emit states; results cannot be stalled.
module dfs_topological_sort (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [5:0]  edge_source,
  input  logic [5:0]  edge_target,
  output logic        done,
  output logic [5:0]  order_vertex,
  output logic        last_vertex,
  output logic        edges_dropped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [6:0]     vertex_count;
  dts_pkg::emit_t emit;
  logic           dropped;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, vertex_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 7'd64;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      vertex_count <= pwdata[6:0];
    end
  end

  dts_engine u_eng (
    .clk(clk), .rst(rst), .vcount(vertex_count), .start(start),
    .operation(operation), .edge_source(edge_source), .edge_target(edge_target),
    .busy(busy), .done(done), .emit(emit), .dropped(dropped)
  );

  assign order_vertex = emit.vertex;
  assign last_vertex = emit.last;
  assign edges_dropped = dropped;
endmodule

FILE: bench/dts_checker.sv
`timescale 1ns / 100ps

module dts_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [5:0]  edge_source,
  input  logic [5:0]  edge_target,
  input  logic        done,
  input  logic [5:0]  order_vertex,
  input  logic        last_vertex,
  input  logic        edges_dropped,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import dts_pkg::*;

  typedef struct packed {
    logic [5:0] vertex;
    logic       last;
    logic       dropped;
  } order_beat_t;

  order_beat_t order_q[$];

  logic [6:0]    vcount;
  logic [5:0]    tgt_mem [MaxEdges];
  logic [EW-1:0] link_mem [MaxEdges];
  logic [EW-1:0] head [MaxVertices];
  logic [EW-1:0] tail [MaxVertices];
  int            n_edges;
  logic          dropped;

  assign pending = order_q.size();

  function automatic int live_count();
    return (vcount > MaxVertices) ? MaxVertices : int'(vcount);
  endfunction

  function automatic void wipe_graph();
    for (int v = 0; v < MaxVertices; v++) begin
      head[v] = NullLink;
      tail[v] = NullLink;
    end
    n_edges = 0;
    dropped = 1'b0;
  endfunction

  function automatic void load_edge(int src, int dst);
    int n;
    n = live_count();
    if (src >= n || dst >= n || n_edges >= MaxEdges) begin
      dropped = 1'b1;
      return;
    end
    tgt_mem[n_edges] = dst[5:0];
    link_mem[n_edges] = NullLink;
    if (tail[src] != NullLink) link_mem[tail[src]] = EW'(n_edges);
    else head[src] = EW'(n_edges);
    tail[src] = EW'(n_edges);
    n_edges++;
  endfunction

  // Iterative depth-first search; queues the reversed postorder as beats.
  function automatic void predict_order();
    int n, sp, cnt, w;
    logic          seen [MaxVertices];
    int            stk_v [MaxVertices];
    logic [EW-1:0] stk_l [MaxVertices];
    int            post [MaxVertices];
    logic [EW-1:0] cur;
    order_beat_t   b;
    n = live_count();
    sp = 0;
    cnt = 0;
    for (int v = 0; v < MaxVertices; v++) seen[v] = 1'b0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        stk_v[0] = root;
        stk_l[0] = head[root];
        sp = 1;
        while (sp > 0) begin
          cur = stk_l[sp-1];
          if (cur == NullLink) begin
            if (cnt < MaxVertices) begin
              post[cnt] = stk_v[sp-1];
              cnt++;
            end
            sp--;
          end else begin
            w = tgt_mem[cur];
            stk_l[sp-1] = link_mem[cur];
            if (w < n && !seen[w] && sp < MaxVertices) begin
              seen[w] = 1'b1;
              stk_v[sp] = w;
              stk_l[sp] = head[w];
              sp++;
            end
          end
        end
      end
    end
    for (int k = 0; k < cnt; k++) begin
      b.vertex = post[cnt-1-k][5:0];
      b.last = (k + 1 == cnt);
      b.dropped = dropped;
      order_q.insert(order_q.size(), b);
    end
  endfunction

  // Sampling mid-cycle keeps the checker clear of edge ordering races.
  always @(negedge clk) begin
    order_beat_t want;
    if (rst) begin
      vcount = 7'd64;
      wipe_graph();
      order_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) vcount = pwdata[6:0];
      if (done) begin
        if (order_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected order beat: vertex %0d last %0b dropped %0b",
                     order_vertex, last_vertex, edges_dropped);
        end else begin
          want = order_q.pop_front();
          if (want.vertex !== order_vertex || want.last !== last_vertex ||
              want.dropped !== edges_dropped) begin
            fail_count++;
            if (fail_count <= 10)
              $display("order beat mismatch: expected v%0d l%0b d%0b, got v%0d l%0b d%0b",
                       want.vertex, want.last, want.dropped,
                       order_vertex, last_vertex, edges_dropped);
          end
        end
      end
      if (start && !busy) begin
        case (op_t'(operation))
          OP_ADD:   load_edge(edge_source, edge_target);
          OP_SORT:  predict_order();
          OP_CLEAR: wipe_graph();
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dts_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [5:0]  edge_source;
  logic [5:0]  edge_target;
  logic        done;
  logic [5:0]  order_vertex;
  logic        last_vertex;
  logic        edges_dropped;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  logic        steady;
  int          quiet_cycles;

  dfs_topological_sort dut (.*);

  dts_checker checker_i (
    .clk, .rst, .start, .busy, .operation, .edge_source, .edge_target,
    .done, .order_vertex, .last_vertex, .edges_dropped,
    .psel, .penable, .pwrite, .paddr, .pwdata, .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: cycles with no accepted beat of any kind.
  always @(negedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 30000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic issue(op_t op, int src, int dst);
    logic ok;
    while (!steady && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    edge_source <= src[5:0];
    edge_target <= dst[5:0];
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_count(int value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_count();
    case ($urandom_range(9))
      0: return 1;
      1: return 2;
      2: return 64;
      3: return 127;
      4: return 0;
      default: return $urandom_range(3, 20);
    endcase
  endfunction

  initial begin
    int n, e, s, d;
    rst = 1'b1;
    start = 1'b0;
    operation = OP_NONE;
    edge_source = '0;
    edge_target = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: a small chain, extremes of the vertex range, a repeat
    // sort, an ignored code, out-of-range edges and the count extremes.
    issue(OP_ADD, 0, 1);
    issue(OP_ADD, 1, 2);
    issue(OP_ADD, 63, 0);
    issue(OP_ADD, 2, 63);
    issue(OP_SORT, 0, 0);
    issue(OP_SORT, 63, 63);
    issue(OP_NONE, 5, 5);
    set_count(4);
    issue(OP_SORT, 0, 0);
    issue(OP_ADD, 4, 0);
    issue(OP_ADD, 0, 63);
    issue(OP_ADD, 3, 3);
    issue(OP_SORT, 0, 0);
    issue(OP_CLEAR, 0, 0);
    issue(OP_SORT, 0, 0);
    set_count(0);
    issue(OP_ADD, 0, 0);
    issue(OP_SORT, 0, 0);
    set_count(127);
    issue(OP_ADD, 10, 20);
    issue(OP_SORT, 0, 0);

    // Fill the edge pool past capacity, without idle gaps.
    set_count(64);
    issue(OP_CLEAR, 0, 0);
    steady = 1'b1;
    for (int i = 0; i < 260; i++)
      issue(OP_ADD, $urandom_range(63), $urandom_range(63));
    steady = 1'b0;
    issue(OP_SORT, 0, 0);

    // Random phases: a count, a fresh graph, edges, then sorts.
    for (int ph = 0; ph < 16; ph++) begin
      n = pick_count();
      set_count(n);
      issue(OP_CLEAR, 0, 0);
      e = $urandom_range(2, 14);
      for (int i = 0; i < e; i++) begin
        if ($urandom_range(9) == 0) begin
          s = $urandom_range(63);
          d = $urandom_range(63);
        end else begin
          s = (n > 1 && n < 64) ? $urandom_range(n - 1) : $urandom_range(63);
          d = (n > 1 && n < 64) ? $urandom_range(n - 1) : $urandom_range(63);
        end
        if ($urandom_range(19) == 0) issue(OP_NONE, s, d);
        issue(OP_ADD, s, d);
      end
      issue(OP_SORT, 0, 0);
      if ($urandom_range(2) == 0) begin
        set_count(n > 2 ? n - 2 : 1);
        issue(OP_SORT, 0, 0);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
